### src/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// checked on every clock edge outside reset
`define XDM_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("xdm assertion failed");

// checked also while reset is asserted
`define XDM_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) (prop)) \
    else $error("xdm assertion failed");

`else

`define XDM_ASSERT(label, prop)
`define XDM_ASSERT_ALWAYS(label, prop)

`endif

`endif

### src/xdm_pkg.sv
package xdm_pkg;

    localparam int CMD_W       = 16;
    localparam int DT_W        = 16;
    localparam int FORCE_W     = 16;
    localparam int MAXF_W      = 15;
    localparam int JERK_W      = 16;
    localparam int SUM_W       = 17;
    localparam int MIX_W       = 18;
    localparam int PROD_W      = 32;
    localparam int STEP_W      = 24;
    localparam int QUO_W       = 15;
    localparam int WHEELS      = 4;
    localparam int WHEEL_W     = 2;
    localparam int DIV_CNT_W   = 4;

    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FORCE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_JERK_RATE = 1'd1;

    localparam logic [MAXF_W-1:0] MAX_FORCE_RST = 15'd32767;
    localparam logic [JERK_W-1:0] JERK_RATE_RST = 16'd1024;

    // q1.15 unity, the smallest normalizing divisor
    localparam logic [SUM_W-1:0] ONE_Q15 = 17'd32768;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = 4'(QUO_W - 1);
    localparam logic [WHEEL_W-1:0]   WHEEL_LAST = 2'(WHEELS - 1);

    typedef struct packed {
        logic               capture;
        logic               prep;
        logic               mul;
        logic               div;
        logic               div_first;
        logic               slew;
        logic               load_out;
        logic [WHEEL_W-1:0] wheel;
    } dp_cmd_t;

endpackage

### src/xdm_in_if.sv
interface xdm_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [xdm_pkg::CMD_W-1:0]    strafe_right;
    logic signed [xdm_pkg::CMD_W-1:0]    drive_forward;
    logic signed [xdm_pkg::CMD_W-1:0]    turn_rate;
    logic        [xdm_pkg::DT_W-1:0]     step_time;

    modport source (
        output valid, strafe_right, drive_forward, turn_rate, step_time,
        input  ready
    );

    modport sink (
        input  valid, strafe_right, drive_forward, turn_rate, step_time,
        output ready
    );
endinterface

### src/xdm_out_if.sv
interface xdm_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [xdm_pkg::FORCE_W-1:0]  front_right_out;
    logic signed [xdm_pkg::FORCE_W-1:0]  front_left_out;
    logic signed [xdm_pkg::FORCE_W-1:0]  back_right_out;
    logic signed [xdm_pkg::FORCE_W-1:0]  back_left_out;

    modport source (
        output valid, front_right_out, front_left_out, back_right_out, back_left_out,
        input  ready
    );

    modport sink (
        input  valid, front_right_out, front_left_out, back_right_out, back_left_out,
        output ready
    );
endinterface

### src/xdm_datapath.sv
module xdm_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  xdm_pkg::dp_cmd_t                      cmd,
    input  logic signed [xdm_pkg::CMD_W-1:0]      strafe_right,
    input  logic signed [xdm_pkg::CMD_W-1:0]      drive_forward,
    input  logic signed [xdm_pkg::CMD_W-1:0]      turn_rate,
    input  logic        [xdm_pkg::DT_W-1:0]       step_time,
    input  logic                                  cfg_we,
    input  logic        [xdm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic        [xdm_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic signed [xdm_pkg::FORCE_W-1:0]    front_right_out,
    output logic signed [xdm_pkg::FORCE_W-1:0]    front_left_out,
    output logic signed [xdm_pkg::FORCE_W-1:0]    back_right_out,
    output logic signed [xdm_pkg::FORCE_W-1:0]    back_left_out
);

    logic        [xdm_pkg::MAXF_W-1:0]   max_force_reg;
    logic        [xdm_pkg::JERK_W-1:0]   jerk_rate_reg;

    logic signed [xdm_pkg::CMD_W-1:0]    s_reg;
    logic signed [xdm_pkg::CMD_W-1:0]    f_reg;
    logic signed [xdm_pkg::CMD_W-1:0]    t_reg;
    logic        [xdm_pkg::DT_W-1:0]     dt_reg;

    logic        [xdm_pkg::SUM_W-1:0]    denom_reg;
    logic        [xdm_pkg::SUM_W-1:0]    denom_next;
    logic        [xdm_pkg::STEP_W-1:0]   step_reg;
    logic        [xdm_pkg::STEP_W-1:0]   step_next;
    logic signed [xdm_pkg::MIX_W-1:0]    mix_reg  [xdm_pkg::WHEELS];
    logic signed [xdm_pkg::MIX_W-1:0]    mix_next [xdm_pkg::WHEELS];

    logic        [xdm_pkg::PROD_W-1:0]   prod_reg;
    logic        [xdm_pkg::PROD_W-1:0]   prod_next;
    logic                                neg_reg;
    logic        [xdm_pkg::SUM_W-1:0]    rem_reg;
    logic        [xdm_pkg::SUM_W-1:0]    rem_next;
    logic        [xdm_pkg::QUO_W-1:0]    quo_reg;

    logic signed [xdm_pkg::FORCE_W-1:0]  force_reg [xdm_pkg::WHEELS];
    logic signed [xdm_pkg::FORCE_W-1:0]  force_next;

    logic signed [xdm_pkg::FORCE_W-1:0]  fr_reg;
    logic signed [xdm_pkg::FORCE_W-1:0]  fl_reg;
    logic signed [xdm_pkg::FORCE_W-1:0]  br_reg;
    logic signed [xdm_pkg::FORCE_W-1:0]  bl_reg;

    // prep stage
    logic signed [xdm_pkg::SUM_W-1:0]    sx, fx, tx;
    logic        [xdm_pkg::SUM_W-1:0]    abs_s, abs_f, abs_t, sum;
    logic signed [xdm_pkg::MIX_W-1:0]    sm, fm, tm;
    logic        [2*xdm_pkg::JERK_W-1:0] jerk_dt;

    // multiply and divide
    logic signed [xdm_pkg::MIX_W-1:0]    mix_sel;
    logic        [xdm_pkg::SUM_W-1:0]    mix_mag;
    logic        [xdm_pkg::SUM_W-1:0]    rem_src;
    logic        [xdm_pkg::SUM_W:0]      trial;
    logic                                q_bit;

    // slew stage
    logic signed [xdm_pkg::MIX_W-1:0]    tgt, cur, delta, moved;
    logic        [xdm_pkg::MIX_W-1:0]    delta_mag;
    logic signed [xdm_pkg::MIX_W-1:0]    step_s;

    always_comb
    begin
        sx = xdm_pkg::SUM_W'(s_reg);
        fx = xdm_pkg::SUM_W'(f_reg);
        tx = xdm_pkg::SUM_W'(t_reg);
        abs_s = sx[xdm_pkg::SUM_W-1] ? xdm_pkg::SUM_W'(-sx) : xdm_pkg::SUM_W'(sx);
        abs_f = fx[xdm_pkg::SUM_W-1] ? xdm_pkg::SUM_W'(-fx) : xdm_pkg::SUM_W'(fx);
        abs_t = tx[xdm_pkg::SUM_W-1] ? xdm_pkg::SUM_W'(-tx) : xdm_pkg::SUM_W'(tx);
        sum = abs_s + abs_f + abs_t;
        denom_next = (sum > xdm_pkg::ONE_Q15) ? sum : xdm_pkg::ONE_Q15;

        sm = xdm_pkg::MIX_W'(s_reg);
        fm = xdm_pkg::MIX_W'(f_reg);
        tm = xdm_pkg::MIX_W'(t_reg);
        mix_next[0] = fm - sm + tm;
        mix_next[1] = fm + sm - tm;
        mix_next[2] = fm + sm + tm;
        mix_next[3] = fm - sm - tm;

        jerk_dt = jerk_rate_reg * dt_reg;
        step_next = jerk_dt[2*xdm_pkg::JERK_W-1:8];
    end

    always_comb
    begin
        mix_sel = mix_reg[cmd.wheel];
        mix_mag = mix_sel[xdm_pkg::MIX_W-1] ? xdm_pkg::SUM_W'(-mix_sel)
                                            : xdm_pkg::SUM_W'(mix_sel);
        prod_next = xdm_pkg::PROD_W'(mix_mag) * xdm_pkg::PROD_W'(max_force_reg);

        // restoring divide, one quotient bit per cycle; the top part is below denom
        rem_src = cmd.div_first ? prod_reg[xdm_pkg::PROD_W-1:xdm_pkg::QUO_W] : rem_reg;
        trial = {rem_src, prod_reg[xdm_pkg::QUO_W-1]};
        q_bit = (trial >= {1'b0, denom_reg});
        rem_next = q_bit ? xdm_pkg::SUM_W'(trial - {1'b0, denom_reg})
                         : trial[xdm_pkg::SUM_W-1:0];
    end

    always_comb
    begin
        tgt = neg_reg ? -xdm_pkg::MIX_W'(quo_reg) : xdm_pkg::MIX_W'(quo_reg);
        cur = xdm_pkg::MIX_W'(force_reg[cmd.wheel]);
        delta = tgt - cur;
        delta_mag = delta[xdm_pkg::MIX_W-1] ? xdm_pkg::MIX_W'(-delta) : xdm_pkg::MIX_W'(delta);
        step_s = signed'({1'b0, step_reg[xdm_pkg::MIX_W-2:0]});
        moved = delta[xdm_pkg::MIX_W-1] ? (cur - step_s) : (cur + step_s);
        // snap when the target is within one step
        if (xdm_pkg::STEP_W'(delta_mag) <= step_reg)
        begin
            force_next = tgt[xdm_pkg::FORCE_W-1:0];
        end
        else
        begin
            force_next = moved[xdm_pkg::FORCE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_force_reg <= xdm_pkg::MAX_FORCE_RST;
            jerk_rate_reg <= xdm_pkg::JERK_RATE_RST;
            for (int i = 0; i < xdm_pkg::WHEELS; i++)
            begin
                force_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    xdm_pkg::CFG_MAX_FORCE: max_force_reg <= cfg_data[xdm_pkg::MAXF_W-1:0];
                    xdm_pkg::CFG_JERK_RATE: jerk_rate_reg <= cfg_data[xdm_pkg::JERK_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.slew)
            begin
                force_reg[cmd.wheel] <= force_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            s_reg  <= strafe_right;
            f_reg  <= drive_forward;
            t_reg  <= turn_rate;
            dt_reg <= step_time;
        end
        if (cmd.prep)
        begin
            denom_reg <= denom_next;
            step_reg  <= step_next;
            for (int i = 0; i < xdm_pkg::WHEELS; i++)
            begin
                mix_reg[i] <= mix_next[i];
            end
        end
        if (cmd.mul)
        begin
            prod_reg <= prod_next;
            neg_reg  <= mix_sel[xdm_pkg::MIX_W-1];
        end
        if (cmd.div)
        begin
            rem_reg  <= rem_next;
            quo_reg  <= {quo_reg[xdm_pkg::QUO_W-2:0], q_bit};
            prod_reg <= prod_reg << 1;
        end
        if (cmd.load_out)
        begin
            fr_reg <= force_reg[0];
            fl_reg <= force_reg[1];
            br_reg <= force_reg[2];
            bl_reg <= force_reg[3];
        end
    end

    assign front_right_out = fr_reg;
    assign front_left_out  = fl_reg;
    assign back_right_out  = br_reg;
    assign back_left_out   = bl_reg;

endmodule

### src/xdm_ctrl.sv
`include "assert_macros.svh"

module xdm_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output xdm_pkg::dp_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PREP = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_SLEW = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0]                      state_reg, state_next;
    logic [xdm_pkg::DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [xdm_pkg::WHEEL_W-1:0]     wheel_reg, wheel_next;
    logic                            out_valid_reg, out_valid_next;
    logic                            in_fire;
    logic                            out_free;
    logic                            slew_last;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign slew_last = (state_reg == ST_SLEW) && (wheel_reg == xdm_pkg::WHEEL_LAST);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        wheel_next     = wheel_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.wheel      = wheel_reg;
        cmd.div_first  = (cnt_reg == '0);

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                wheel_next = '0;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div = 1'b1;
                if (cnt_reg == xdm_pkg::DIV_LAST)
                begin
                    state_next = ST_SLEW;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_SLEW:
            begin
                cmd.slew = 1'b1;
                if (wheel_reg == xdm_pkg::WHEEL_LAST)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    wheel_next = wheel_reg + 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_DONE:
            begin
                // wait for the output register to free up
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            wheel_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            wheel_reg     <= wheel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `XDM_ASSERT(a_accept_to_prep, in_fire |=> (state_reg == ST_PREP))
    `XDM_ASSERT(a_div_count_bound, (state_reg == ST_DIV) |-> (cnt_reg <= xdm_pkg::DIV_LAST))
    `XDM_ASSERT(a_last_wheel_done, slew_last |=> (state_reg == ST_DONE))
    `XDM_ASSERT(a_load_sets_valid, cmd.load_out |=> out_valid_reg)
    `XDM_ASSERT(a_no_load_while_full, cmd.load_out |-> out_free)

endmodule

### src/xdrive_mixer_slew_limiter_core.sv
// X-drive wheel mixer with slew limit. Each command item (strafe, forward, turn in q1.15
// and a time step in microseconds) yields one result item with the four new motor forces,
// front right, front left, back right, back left. The mix is normalized by |s|+|f|+|t| when
// that exceeds one, scaled by max_force, and each stored force then moves toward its target
// by at most jerk_rate*step_time/256. From acceptance an item passes a prep step, then per wheel
// a multiply, a restoring divide with one quotient bit per cycle and a slew, then the output
// load; the single shared divider is used once per wheel. No new item is accepted until the
// result is loaded. The result sits in an output register, so the next item is taken while it
// waits. max_force and jerk_rate sit at indexes 0 and 1 of the config port; the user must write
// them only while the block is idle, which the block itself does not enforce; motor forces reset to zero.
module xdrive_mixer_slew_limiter_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    xdm_in_if.sink                                in_item,
    xdm_out_if.source                             out_item,
    input  logic                                  cfg_we,
    input  logic        [xdm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic        [xdm_pkg::CFG_DATA_W-1:0] cfg_data
);

    xdm_pkg::dp_cmd_t cmd;

    xdm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_item.valid),
        .in_ready  (in_item.ready),
        .out_valid (out_item.valid),
        .out_ready (out_item.ready),
        .cmd       (cmd)
    );

    xdm_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .strafe_right    (in_item.strafe_right),
        .drive_forward   (in_item.drive_forward),
        .turn_rate       (in_item.turn_rate),
        .step_time       (in_item.step_time),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .front_right_out (out_item.front_right_out),
        .front_left_out  (out_item.front_left_out),
        .back_right_out  (out_item.back_right_out),
        .back_left_out   (out_item.back_left_out)
    );

endmodule

### verif/xdm_force_checker.sv
module xdm_force_checker
    import xdm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    xdm_in_if                     in_mon,
    xdm_out_if                    out_mon,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [FORCE_W-1:0] front_right;
        logic signed [FORCE_W-1:0] front_left;
        logic signed [FORCE_W-1:0] back_right;
        logic signed [FORCE_W-1:0] back_left;
    } wheel_forces_t;

    logic        [MAXF_W-1:0]  max_force;
    logic        [JERK_W-1:0]  jerk_rate;
    logic signed [FORCE_W-1:0] motor_force [WHEELS];

    wheel_forces_t expected_forces [$];
    int            mismatches;

    // sign(mix) * floor(|mix| * max_force / denom)
    function automatic logic signed [FORCE_W-1:0] wheel_goal(
        input logic signed [MIX_W-1:0] mix,
        input logic        [SUM_W-1:0] denom
    );
        logic [MIX_W-1:0]  mag;
        logic [PROD_W-1:0] prod;
        logic [QUO_W-1:0]  quo;
        mag  = (mix < 0) ? MIX_W'(-mix) : MIX_W'(mix);
        prod = PROD_W'(mag) * PROD_W'(max_force);
        quo  = QUO_W'(prod / PROD_W'(denom));
        return (mix < 0) ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    endfunction

    function automatic logic signed [FORCE_W-1:0] slew_toward(
        input logic signed [FORCE_W-1:0] cur,
        input logic signed [FORCE_W-1:0] goal,
        input logic        [STEP_W-1:0]  step
    );
        int delta;
        int delta_mag;
        delta     = int'(goal) - int'(cur);
        delta_mag = (delta < 0) ? -delta : delta;
        if (delta_mag <= int'(step))
            return goal;
        if (delta > 0)
            return FORCE_W'(int'(cur) + int'(step));
        return FORCE_W'(int'(cur) - int'(step));
    endfunction

    function automatic wheel_forces_t advance_forces(
        input logic signed [CMD_W-1:0] s,
        input logic signed [CMD_W-1:0] f,
        input logic signed [CMD_W-1:0] t,
        input logic        [DT_W-1:0]  dt
    );
        logic        [SUM_W-1:0]  sum;
        logic        [SUM_W-1:0]  denom;
        logic        [PROD_W-1:0] jerk_prod;
        logic        [STEP_W-1:0] step;
        logic signed [MIX_W-1:0]  mix [WHEELS];
        wheel_forces_t            res;
        int                       sa;
        int                       fa;
        int                       ta;
        sa = (s < 0) ? -int'(s) : int'(s);
        fa = (f < 0) ? -int'(f) : int'(f);
        ta = (t < 0) ? -int'(t) : int'(t);
        sum   = SUM_W'(sa + fa + ta);
        denom = (sum > ONE_Q15) ? sum : ONE_Q15;
        jerk_prod = PROD_W'(jerk_rate) * PROD_W'(dt);
        step      = STEP_W'(jerk_prod >> 8);
        mix[0] = MIX_W'(int'(f) - int'(s) + int'(t));
        mix[1] = MIX_W'(int'(f) + int'(s) - int'(t));
        mix[2] = MIX_W'(int'(f) + int'(s) + int'(t));
        mix[3] = MIX_W'(int'(f) - int'(s) - int'(t));
        for (int w = 0; w < WHEELS; w++)
            motor_force[w] = slew_toward(motor_force[w], wheel_goal(mix[w], denom), step);
        res.front_right = motor_force[0];
        res.front_left  = motor_force[1];
        res.back_right  = motor_force[2];
        res.back_left   = motor_force[3];
        return res;
    endfunction

    function automatic void check_field(
        input string                     name,
        input logic signed [FORCE_W-1:0] exp_val,
        input logic signed [FORCE_W-1:0] act_val
    );
        if (act_val !== exp_val)
        begin
            $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        wheel_forces_t exp_item;
        if (!rst_n)
        begin
            max_force = MAX_FORCE_RST;
            jerk_rate = JERK_RATE_RST;
            for (int w = 0; w < WHEELS; w++)
                motor_force[w] = '0;
            expected_forces.delete();
            mismatches = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MAX_FORCE: max_force = cfg_data[MAXF_W-1:0];
                    CFG_JERK_RATE: jerk_rate = cfg_data[JERK_W-1:0];
                    default: ;
                endcase
            end
            if (in_mon.valid && in_mon.ready)
                expected_forces.push_back(advance_forces(in_mon.strafe_right,
                    in_mon.drive_forward, in_mon.turn_rate, in_mon.step_time));
            if (out_mon.valid && out_mon.ready)
            begin
                if (expected_forces.size() == 0)
                begin
                    $error("result item with no command waiting");
                    mismatches++;
                end
                else
                begin
                    exp_item = expected_forces.pop_front();
                    check_field("front_right_out", exp_item.front_right,
                        out_mon.front_right_out);
                    check_field("front_left_out", exp_item.front_left,
                        out_mon.front_left_out);
                    check_field("back_right_out", exp_item.back_right,
                        out_mon.back_right_out);
                    check_field("back_left_out", exp_item.back_left,
                        out_mon.back_left_out);
                end
            end
        end
        fail_count <= mismatches;
        pending    <= expected_forces.size();
    end

endmodule

### verif/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import xdm_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_CYCLES  = 700;
    localparam int DRAIN_CYCLES = 80;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;
    int                    cycle_count = 0;
    int                    results_taken;
    bit                    in_steady = 1'b0;
    bit                    out_steady = 1'b0;

    xdm_in_if  in_bus ();
    xdm_out_if out_bus ();

    xdrive_mixer_slew_limiter_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_bus),
        .out_item  (out_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    xdm_force_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_mon     (in_bus),
        .out_mon    (out_bus),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // extremes, zero and small magnitudes weighted up
    function automatic logic signed [CMD_W-1:0] pick_command();
        case ($urandom_range(0, 6))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return '0;
            3: return CMD_W'($signed($urandom_range(0, 512)) - 256);
            default: return CMD_W'($urandom);
        endcase
    endfunction

    function automatic logic [DT_W-1:0] pick_step_time();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return DT_W'($urandom_range(0, 31));
            3: return DT_W'($urandom_range(0, 1023));
            default: return DT_W'($urandom);
        endcase
    endfunction

    // called at a rising edge, returns at the edge where the item is taken
    task automatic send_command(
        input logic signed [CMD_W-1:0] s,
        input logic signed [CMD_W-1:0] f,
        input logic signed [CMD_W-1:0] t,
        input logic        [DT_W-1:0]  dt
    );
        int gap;
        if ($urandom_range(0, 40) == 0)
            in_steady = !in_steady;
        gap = in_steady ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_bus.valid         <= 1'b1;
        in_bus.strafe_right  <= s;
        in_bus.drive_forward <= f;
        in_bus.turn_rate     <= t;
        in_bus.step_time     <= dt;
        do @(posedge clk); while (!in_bus.ready);
    endtask

    task automatic send_random(input int count);
        repeat (count)
            send_command(pick_command(), pick_command(), pick_command(), pick_step_time());
    endtask

    // block is idle once every result is back
    task automatic wait_idle();
        in_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_config(input logic [CFG_DATA_W-1:0] force_val,
                                input logic [CFG_DATA_W-1:0] jerk_val);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MAX_FORCE;
        cfg_data  <= force_val;
        @(posedge clk);
        cfg_index <= CFG_JERK_RATE;
        cfg_data  <= jerk_val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // result side: random stalls, plus long hold-offs that back the block up
    initial
    begin
        int gap;
        out_bus.ready <= 1'b0;
        results_taken = 0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 40) == 0)
                out_steady = !out_steady;
            gap = out_steady ? 0 : $urandom_range(0, 16);
            if (results_taken == 150 || results_taken == 800)
                gap = HOLD_CYCLES;
            if (gap > 0)
            begin
                out_bus.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_bus.ready <= 1'b1;
            do @(posedge clk); while (!out_bus.valid);
            results_taken++;
        end
    end

    initial
    begin
        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_index            <= CFG_MAX_FORCE;
        cfg_data             <= '0;
        in_bus.valid         <= 1'b0;
        in_bus.strafe_right  <= '0;
        in_bus.drive_forward <= '0;
        in_bus.turn_rate     <= '0;
        in_bus.step_time     <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: full force, step of 4 per microsecond
        send_command('0, '0, '0, '0);
        send_command(16'sh7fff, '0, '0, 16'hffff);
        send_command(16'sh7fff, '0, '0, 16'hffff);   // already at target
        send_command(16'sh8000, '0, '0, 16'hffff);
        send_command('0, 16'sh8000, '0, 16'd10);     // slew limited
        send_command('0, 16'sh7fff, '0, 16'd1);
        send_command('0, '0, 16'sh7fff, '0);         // zero step holds
        send_command('0, '0, 16'sh8000, 16'hffff);
        send_command(16'sh8000, 16'sh8000, 16'sh8000, 16'hffff);
        send_command(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'd100);
        send_command(16'sh7fff, 16'sh8000, 16'sh7fff, 16'hffff);
        send_command(16'sh4000, 16'sh4000, '0, 16'hffff);       // sum exactly one
        send_command(16'sh4000, 16'sh4000, 16'sh0001, 16'hffff);
        send_command(16'sh0001, -16'sh0001, 16'sh0001, 16'd3);
        send_command(-16'sh0001, -16'sh0001, -16'sh0001, 16'hffff);
        send_command(16'sd12345, -16'sd20000, 16'sd8000, 16'd7);
        send_command('0, '0, '0, 16'hffff);
        send_random(160);
        wait_idle();

        write_config(16'h8000, 16'hffff);            // top bit of force is dropped
        send_command(16'sh7fff, 16'sh7fff, '0, 16'd1);
        send_random(165);
        wait_idle();

        write_config(16'h7fff, 16'h0000);
        send_random(165);
        wait_idle();

        write_config(16'h0001, 16'h0001);
        send_random(165);
        wait_idle();

        write_config(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
        send_random(165);
        wait_idle();

        write_config(16'h7fff, 16'hffff);
        send_random(165);
        wait_idle();

        write_config(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom_range(0, 4096)));
        send_random(165);
        wait_idle();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

### files.f
+incdir+src
src/xdm_pkg.sv
src/xdm_in_if.sv
src/xdm_out_if.sv
src/xdm_datapath.sv
src/xdm_ctrl.sv
src/xdrive_mixer_slew_limiter_core.sv
verif/xdm_force_checker.sv
verif/testbench.sv
